/* rtl/dbt_pkg.sv */
// Shared types and constants of the divisibility-by-three-divisors block.
// No dependencies; imported by every module of the block.
package dbt_pkg;

    localparam int NUM_DIVISORS   = 3;
    localparam int REM_FIELD_BITS = 16;

    localparam int DIV_FIRST_RESET  = 3;
    localparam int DIV_SECOND_RESET = 37;
    localparam int DIV_THIRD_RESET  = 89;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_DIVISOR_FIRST  = 2'd0;
    localparam t_cfg_index CFG_DIVISOR_SECOND = 2'd1;
    localparam t_cfg_index CFG_DIVISOR_THIRD  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_step_ctrl;

endpackage

/* rtl/dbt_bit_cell.sv */
// One cell of the dividend shift chain: holds one dividend bit.
// Loads in parallel on a new request, then passes its bit up the chain.
// Depends on dbt_pkg.
module dbt_bit_cell (
    input  logic                i_clk,
    input  dbt_pkg::t_step_ctrl i_ctrl,
    input  logic                i_load_bit,
    input  logic                i_shift_bit,
    output logic                o_bit
);
    import dbt_pkg::*;

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctrl.load) begin
            n_bit = i_load_bit;
        end else if (i_ctrl.shift) begin
            n_bit = i_shift_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

/* rtl/dbt_rem_cell.sv */
// Restoring shift-subtract remainder cell for one divisor.
// Takes one dividend bit per step; a zero divisor leaves the low dividend bits.
// Depends on dbt_pkg.
module dbt_rem_cell #(
    parameter int DIVISOR_BITS = 16
) (
    input  logic                               i_clk,
    input  dbt_pkg::t_step_ctrl                i_ctrl,
    input  logic                               i_bit,
    input  logic [DIVISOR_BITS-1:0]            i_divisor,
    output logic [dbt_pkg::REM_FIELD_BITS-1:0] o_rem_field,
    output logic                               o_zero
);
    import dbt_pkg::*;

    logic [DIVISOR_BITS-1:0]                r_rem;
    logic [DIVISOR_BITS-1:0]                n_rem;
    logic [DIVISOR_BITS:0]                  w_trial;
    logic [DIVISOR_BITS:0]                  w_den;
    logic [DIVISOR_BITS+REM_FIELD_BITS-1:0] w_ext;

    always_comb begin
        w_trial = {r_rem, i_bit};
        w_den   = {1'b0, i_divisor};
        n_rem   = r_rem;
        if (i_ctrl.load) begin
            n_rem = '0;
        end else if (i_ctrl.shift) begin
            if (w_trial >= w_den) begin
                n_rem = DIVISOR_BITS'(w_trial - w_den);
            end else begin
                n_rem = w_trial[DIVISOR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

    assign w_ext       = {{REM_FIELD_BITS{1'b0}}, r_rem};
    assign o_rem_field = w_ext[REM_FIELD_BITS-1:0];
    assign o_zero      = (o_rem_field == '0);

endmodule

/* rtl/divisibility_by_three_divisors.sv */
// Divisibility test of one dividend against three divisors. A request is taken
// only while the block is idle; the dividend is loaded into a chain of one-bit
// cells and shifted out MSB first, one bit per cycle, into three restoring
// remainder cells; a request passes through a load, one step per dividend
// bit and a hand-off to the output register. The output register holds the
// result until taken, and the next request is accepted while it waits.
// Divisors reset to 3, 37 and 89; a zero divisor yields the low dividend
// bits. Depends on dbt_pkg, dbt_bit_cell and dbt_rem_cell.
module divisibility_by_three_divisors #(
    parameter int DIVIDEND_BITS = 31,
    parameter int DIVISOR_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  dbt_pkg::t_cfg_index                i_cfg_index,
    input  logic [DIVISOR_BITS-1:0]            i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [DIVIDEND_BITS-1:0]           i_dividend,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_divides_first,
    output logic [dbt_pkg::REM_FIELD_BITS-1:0] o_remainder_first,
    output logic                               o_divides_second,
    output logic [dbt_pkg::REM_FIELD_BITS-1:0] o_remainder_second,
    output logic                               o_divides_third,
    output logic [dbt_pkg::REM_FIELD_BITS-1:0] o_remainder_third
);
    import dbt_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_BITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_BITS - 1);

    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_count;
    logic [DIVISOR_BITS-1:0]   r_divisor [NUM_DIVISORS];
    logic                      r_out_valid;
    logic [REM_FIELD_BITS-1:0] r_out_rem [NUM_DIVISORS];
    logic                      r_out_zero [NUM_DIVISORS];

    t_step_ctrl                w_ctrl;
    logic                      w_accept;
    logic                      w_out_load;
    logic [DIVIDEND_BITS-1:0]  w_chain;
    logic [REM_FIELD_BITS-1:0] w_field [NUM_DIVISORS];
    logic                      w_zero [NUM_DIVISORS];

    // dividend chain, MSB cell feeds the remainder cells
    for (genvar k = 0; k < DIVIDEND_BITS; k++) begin : g_chain
        if (k == 0) begin : g_tail
            dbt_bit_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_load_bit  (i_dividend[k]),
                .i_shift_bit (1'b0),
                .o_bit       (w_chain[k])
            );
        end else begin : g_body
            dbt_bit_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_load_bit  (i_dividend[k]),
                .i_shift_bit (w_chain[k-1]),
                .o_bit       (w_chain[k])
            );
        end
    end

    for (genvar d = 0; d < NUM_DIVISORS; d++) begin : g_rem
        dbt_rem_cell #(
            .DIVISOR_BITS (DIVISOR_BITS)
        ) u_rem (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_bit       (w_chain[DIVIDEND_BITS-1]),
            .i_divisor   (r_divisor[d]),
            .o_rem_field (w_field[d]),
            .o_zero      (w_zero[d])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_count == LAST_STEP) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall      = (r_state != ST_IDLE);
        w_accept     = i_valid && (r_state == ST_IDLE);
        w_ctrl.load  = w_accept;
        w_ctrl.shift = (r_state == ST_RUN);
        w_out_load   = (r_state == ST_DRAIN) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= '0;
            end else if (w_ctrl.shift) begin
                r_count <= r_count + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor[0] <= DIVISOR_BITS'(DIV_FIRST_RESET);
            r_divisor[1] <= DIVISOR_BITS'(DIV_SECOND_RESET);
            r_divisor[2] <= DIVISOR_BITS'(DIV_THIRD_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIVISOR_FIRST:  r_divisor[0] <= i_cfg_data;
                CFG_DIVISOR_SECOND: r_divisor[1] <= i_cfg_data;
                CFG_DIVISOR_THIRD:  r_divisor[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            for (int d = 0; d < NUM_DIVISORS; d++) begin
                r_out_rem[d]  <= w_field[d];
                r_out_zero[d] <= w_zero[d];
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_divides_first    = r_out_zero[0];
    assign o_remainder_first  = r_out_rem[0];
    assign o_divides_second   = r_out_zero[1];
    assign o_remainder_second = r_out_rem[1];
    assign o_divides_third    = r_out_zero[2];
    assign o_remainder_third  = r_out_rem[2];

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_RUN) && (r_count == '0))
        else $error("request did not start a run");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_count == LAST_STEP) |=> (r_state == ST_DRAIN))
        else $error("run did not end after last dividend bit");

    a_drain_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_valid && (r_state == ST_IDLE))
        else $error("finished result not presented");

    a_flag_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_divides_first == (o_remainder_first == '0)))
        else $error("first divides flag disagrees with remainder");
`endif

endmodule
